// File: rtl/core/morse_key_decoder_assert.svh
// ----------------------------------------------------------------------------
// Morse key decoder assertion macros
// Concurrent assertion wrappers clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_DECODER_ASSERT_SVH
`define MORSE_KEY_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MKD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, event codes and the letter decode table of the Morse key
// decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam logic [2:0] EV_DOT     = 3'd0;
    localparam logic [2:0] EV_DASH    = 3'd1;
    localparam logic [2:0] EV_SEP     = 3'd2;
    localparam logic [2:0] EV_LETTER  = 3'd3;
    localparam logic [2:0] EV_NOMATCH = 3'd4;

    localparam logic [2:0] SYMS_PER_LETTER = 3'd4;
    localparam logic [7:0] DASH_THR_RESET  = 8'd2;
    localparam int         TABLE_SIZE      = 24;

    // One letter: symbol count and symbols, first symbol highest, 1 is a dash.
    typedef struct packed {
        logic [2:0] cnt;
        logic [3:0] pat;
    } t_entry;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } t_dec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYM,
        ST_AUTO,
        ST_PREP,
        ST_SHOW,
        ST_END
    } t_state;

    typedef struct packed {
        logic tick;
        logic emit_sym;
        logic close_auto;
        logic show_init;
        logic show_emit;
        logic close_end;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic sym_pend;
        logic auto_now;
        logic show_req;
        logic end_ok_next;
        logic end_ok_now;
        logic show_last;
        logic out_free;
    } t_stat;

    localparam logic [6:0] CODE_TAB [TABLE_SIZE] = '{
        7'h21, 7'h48, 7'h4A, 7'h34, 7'h10, 7'h42, 7'h36, 7'h40,
        7'h20, 7'h47, 7'h35, 7'h44, 7'h23, 7'h22, 7'h37, 7'h46,
        7'h32, 7'h30, 7'h11, 7'h31, 7'h33, 7'h49, 7'h4B, 7'h4C
    };

    localparam logic [7:0] CHAR_TAB [TABLE_SIZE] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
        8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
        8'h72, 8'h73, 8'h74, 8'h75, 8'h77, 8'h78, 8'h79, 8'h7A
    };

    function automatic t_dec decode(input t_entry e);
        t_dec d;
        d = '0;
        for (int j = TABLE_SIZE - 1; j >= 0; j--) begin
            if (e == CODE_TAB[j]) begin
                d.hit = 1'b1;
                d.ch  = CHAR_TAB[j];
            end
        end
        return d;
    endfunction

endpackage

// File: rtl/core/morse_key_decoder.sv
// ----------------------------------------------------------------------------
// morse_key_decoder
// Morse key decoder: turns sampled key ticks into dot, dash, separator and
// decoded letter events.
// ----------------------------------------------------------------------------
// One input transfer is one sampling tick. The block takes a tick, then
// steps through key handling, automatic letter close, an optional show walk
// and end-letter, emitting at most one result per cycle through an output
// register. A tick with show adds a prepare step and one show step per
// letter walked (up to MAX_LETTERS), as the single read port of the letter
// store delivers one entry a cycle while the output side does not stall.
// An output stall holds any step that has a result to emit.
// The input is stalled until the sequencer is back in idle after end-letter.
// ----------------------------------------------------------------------------
`include "morse_key_decoder_assert.svh"

module morse_key_decoder #(
    parameter int MAX_LETTERS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_key_down,
    input  logic       i_clear_all,
    input  logic       i_show_text,
    input  logic       i_end_letter,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_letter,
    output logic       o_last
);

    mkd_pkg::t_cmd  cmd;
    mkd_pkg::t_stat stat;

    mkd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mkd_datapath #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_key_down   (i_key_down),
        .i_clear_all  (i_clear_all),
        .i_show_text  (i_show_text),
        .i_end_letter (i_end_letter),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_letter     (o_letter),
        .o_last       (o_last)
    );

    `MKD_ASSERT_NEXT(a_busy_after_tick, i_in_valid && !o_in_stall, o_in_stall, "tick not sequenced")
    `MKD_ASSERT_SAME(a_one_result, 1'b1, $onehot0({cmd.emit_sym, cmd.close_auto, cmd.show_emit, cmd.close_end}), "two results in one cycle")
    `MKD_ASSERT_SAME(a_no_overwrite, cmd.emit_sym || cmd.close_auto || cmd.show_emit || cmd.close_end, !o_out_valid || !i_out_stall, "result overwrites a stalled one")

endmodule

// File: rtl/core/mkd_ctrl.sv
// ----------------------------------------------------------------------------
// mkd_ctrl
// Sequencer of one tick: key handling, automatic close, show walk and
// end-letter, at most one result per step, each marked last when nothing follows.
// ----------------------------------------------------------------------------
module mkd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mkd_pkg::t_stat i_stat,
    output mkd_pkg::t_cmd  o_cmd
);

    mkd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mkd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != mkd_pkg::ST_IDLE) || !i_rst_n;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            mkd_pkg::ST_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.tick = 1'b1;
                    n_state    = mkd_pkg::ST_SYM;
                end
            end
            mkd_pkg::ST_SYM: begin
                if (!i_stat.sym_pend) begin
                    n_state = mkd_pkg::ST_AUTO;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_sym = 1'b1;
                    o_cmd.last     = !(i_stat.auto_now || i_stat.show_req ||
                                       i_stat.end_ok_next);
                    n_state        = mkd_pkg::ST_AUTO;
                end
            end
            mkd_pkg::ST_AUTO: begin
                if (!i_stat.auto_now || i_stat.out_free) begin
                    if (i_stat.auto_now) begin
                        o_cmd.close_auto = 1'b1;
                        o_cmd.last       = !(i_stat.show_req || i_stat.end_ok_next);
                    end
                    n_state = i_stat.show_req ? mkd_pkg::ST_PREP : mkd_pkg::ST_END;
                end
            end
            mkd_pkg::ST_PREP: begin
                // The store read for the first entry is issued here, after any automatic close.
                o_cmd.show_init = 1'b1;
                n_state         = mkd_pkg::ST_SHOW;
            end
            mkd_pkg::ST_SHOW: begin
                if (i_stat.out_free) begin
                    o_cmd.show_emit = 1'b1;
                    o_cmd.last      = i_stat.show_last && !i_stat.end_ok_now;
                    if (i_stat.show_last) begin
                        n_state = mkd_pkg::ST_END;
                    end
                end
            end
            mkd_pkg::ST_END: begin
                if (!i_stat.end_ok_now) begin
                    n_state = mkd_pkg::ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.close_end = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_state         = mkd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mkd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/mkd_datapath.sv
// ----------------------------------------------------------------------------
// mkd_datapath
// Press timing, the letter being built, the letter store memory, the
// decode table lookup and the result register.
// ----------------------------------------------------------------------------
module mkd_datapath #(
    parameter int MAX_LETTERS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_key_down,
    input  logic           i_clear_all,
    input  logic           i_show_text,
    input  logic           i_end_letter,
    input  mkd_pkg::t_cmd  i_cmd,
    output mkd_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [2:0]     o_event_kind,
    output logic [7:0]     o_letter,
    output logic           o_last
);

    localparam int AW = $clog2(MAX_LETTERS);
    localparam int IW = $clog2(MAX_LETTERS + 1);
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_LETTERS);

    logic [7:0]       r_thr;
    logic [7:0]       r_hold, n_hold;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_idx, n_idx;
    mkd_pkg::t_entry  r_cur, n_cur;
    logic             r_sym, r_dash, r_show, r_endl;
    logic [AW-1:0]    r_ptr, n_ptr;
    mkd_pkg::t_entry  r_rd;
    mkd_pkg::t_entry  r_mem [MAX_LETTERS];
    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_kind, n_kind;
    logic [7:0]       r_letter, n_letter;
    logic             r_last, n_last;

    mkd_pkg::t_entry  tick_cur, show_entry;
    logic [IW-1:0]    tick_idx, last_ent;
    logic             tick_sym, tick_dash, idx_ok, auto_now, any_close, emit;
    mkd_pkg::t_dec    dec;

    // Clear is applied ahead of the key handling within the same tick.
    assign tick_cur  = i_clear_all ? '0 : r_cur;
    assign tick_idx  = i_clear_all ? '0 : r_idx;
    assign tick_sym  = !i_key_down && r_pend && (tick_idx < MAX_IDX);
    assign tick_dash = r_hold > r_thr;

    assign idx_ok    = r_idx < MAX_IDX;
    assign auto_now  = idx_ok && (r_cur.cnt >= mkd_pkg::SYMS_PER_LETTER);
    assign any_close = i_cmd.close_auto || i_cmd.close_end;
    assign last_ent  = idx_ok ? r_idx : MAX_IDX - IW'(1);

    // The letter in progress lives in r_cur; closed letters come from the store.
    assign show_entry = (idx_ok && (IW'(r_ptr) == r_idx)) ? r_cur : r_rd;
    assign dec        = mkd_pkg::decode(show_entry);

    assign o_stat.sym_pend    = r_sym;
    assign o_stat.auto_now    = auto_now;
    assign o_stat.show_req    = r_show;
    assign o_stat.end_ok_next = r_endl && (auto_now ? (r_idx < MAX_IDX - IW'(1)) : idx_ok);
    assign o_stat.end_ok_now  = r_endl && idx_ok;
    assign o_stat.show_last   = IW'(r_ptr) == last_ent;
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    assign emit = i_cmd.emit_sym || i_cmd.close_auto || i_cmd.show_emit || i_cmd.close_end;

    always_comb begin
        n_hold = r_hold;
        n_pend = r_pend;
        n_idx  = r_idx;
        n_cur  = r_cur;
        n_ptr  = r_ptr;
        if (i_cmd.tick) begin
            n_idx = tick_idx;
            n_cur = tick_cur;
            if (i_key_down) begin
                n_hold = (r_hold == 8'hFF) ? r_hold : r_hold + 8'd1;
                n_pend = 1'b1;
            end else if (r_pend) begin
                n_hold = '0;
                n_pend = 1'b0;
            end
            if (tick_sym && (tick_cur.cnt < mkd_pkg::SYMS_PER_LETTER)) begin
                n_cur.cnt = tick_cur.cnt + 3'd1;
                n_cur.pat = {tick_cur.pat[2:0], tick_dash};
            end
        end
        if (any_close) begin
            n_idx = r_idx + IW'(1);
            n_cur = '0;
        end
        if (i_cmd.show_init) begin
            n_ptr = '0;
        end else if (i_cmd.show_emit && !o_stat.show_last) begin
            n_ptr = r_ptr + AW'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_letter    = r_letter;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_last      = i_cmd.last;
            n_letter    = '0;
            if (i_cmd.emit_sym) begin
                n_kind = r_dash ? mkd_pkg::EV_DASH : mkd_pkg::EV_DOT;
            end else if (i_cmd.show_emit) begin
                n_kind   = dec.hit ? mkd_pkg::EV_LETTER : mkd_pkg::EV_NOMATCH;
                n_letter = dec.hit ? dec.ch : 8'd0;
            end else begin
                n_kind = mkd_pkg::EV_SEP;
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= mkd_pkg::DASH_THR_RESET;
            r_hold      <= '0;
            r_pend      <= 1'b0;
            r_idx       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_hold      <= n_hold;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_sym  <= tick_sym;
            r_dash <= tick_dash;
            r_show <= i_show_text;
            r_endl <= i_end_letter;
        end
        r_ptr    <= n_ptr;
        r_kind   <= n_kind;
        r_letter <= n_letter;
        r_last   <= n_last;
    end

    // Letter store: a closed letter is written at its index, read one per cycle.
    always_ff @(posedge i_clk) begin
        if (any_close) begin
            r_mem[r_idx[AW-1:0]] <= r_cur;
        end
        r_rd <= r_mem[n_ptr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_letter     = r_letter;
    assign o_last       = r_last;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Morse key decoder. Key ticks go in through a
// valid/stall channel, and a scoreboard with its own decoder state predicts
// every dot, dash, separator, decoded letter and no-match result. The output
// side checks each transfer in order. Both sides idle at random, and one long
// output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

    localparam int LETTERS = 16;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] letter;
        logic       last;
    } t_morse_event;

    class morse_scoreboard;
        logic [7:0]       dash_thr;
        logic [7:0]       hold_ticks;
        bit               key_held;
        mkd_pkg::t_entry  letters [LETTERS];
        int unsigned      letter_idx;
        t_morse_event     tick_events [$];
        t_morse_event     pending_events [$];
        int               errors;
        string            morse_tab [24];
        string            alphabet;

        function new();
            morse_tab = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
                          "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
                          ".-.", "...", "-", "..-", ".--", "-..-", "-.--", "--.."};
            alphabet   = "abcdefghijklmnoprstuwxyz";
            dash_thr   = mkd_pkg::DASH_THR_RESET;
            hold_ticks = '0;
            key_held   = 1'b0;
            foreach (letters[i]) letters[i] = '0;
            letter_idx = 0;
            errors     = 0;
        endfunction

        function void add_event(logic [2:0] kind, logic [7:0] ch);
            t_morse_event ev;
            ev.kind   = kind;
            ev.letter = ch;
            ev.last   = 1'b0;
            tick_events.push_back(ev);
        endfunction

        function void close_letter();
            if (letter_idx < LETTERS) begin
                letter_idx++;
                add_event(mkd_pkg::EV_SEP, 8'h00);
            end
        endfunction

        // Spell the entry out in dots and dashes and look it up by name.
        function logic [7:0] lookup_letter(mkd_pkg::t_entry e);
            string m;
            m = "";
            if (e.cnt > 4) return 8'h00;
            for (int i = int'(e.cnt) - 1; i >= 0; i--) begin
                if (e.pat[i]) m = {m, "-"};
                else m = {m, "."};
            end
            for (int j = 0; j < 24; j++) begin
                if (m == morse_tab[j]) return alphabet[j];
            end
            return 8'h00;
        endfunction

        function void apply_tick(bit key, bit clr, bit show, bit endl);
            mkd_pkg::t_entry e;
            logic            dash;
            logic [7:0]      ch;
            int unsigned     walk;
            tick_events.delete();
            if (clr) begin
                foreach (letters[i]) letters[i] = '0;
                letter_idx = 0;
            end
            if (key) begin
                if (hold_ticks != 8'hFF) hold_ticks++;
                key_held = 1'b1;
            end else if (key_held) begin
                dash = hold_ticks > dash_thr;
                if (letter_idx < LETTERS) begin
                    e = letters[letter_idx];
                    if (e.cnt < mkd_pkg::SYMS_PER_LETTER) begin
                        e.pat = {e.pat[2:0], dash};
                        e.cnt = e.cnt + 3'd1;
                        letters[letter_idx] = e;
                    end
                    add_event(dash ? mkd_pkg::EV_DASH : mkd_pkg::EV_DOT, 8'h00);
                end
                hold_ticks = '0;
                key_held   = 1'b0;
            end
            if (letter_idx < LETTERS &&
                letters[letter_idx].cnt >= mkd_pkg::SYMS_PER_LETTER)
                close_letter();
            if (show) begin
                walk = (letter_idx < LETTERS) ? letter_idx + 1 : LETTERS;
                for (int i = 0; i < walk; i++) begin
                    ch = lookup_letter(letters[i]);
                    if (ch != 8'h00) add_event(mkd_pkg::EV_LETTER, ch);
                    else add_event(mkd_pkg::EV_NOMATCH, 8'h00);
                end
            end
            if (endl) close_letter();
            if (tick_events.size() > 0) tick_events[$].last = 1'b1;
            foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_event(logic [2:0] kind, logic [7:0] ch, logic last);
            t_morse_event want;
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected result kind %0d letter %h last %b",
                                 kind, ch, last));
                return;
            end
            want = pending_events.pop_front();
            if (kind !== want.kind)
                report($sformatf("event_kind %0d, want %0d", kind, want.kind));
            if (ch !== want.letter)
                report($sformatf("letter %h, want %h", ch, want.letter));
            if (last !== want.last)
                report($sformatf("last %b, want %b", last, want.last));
        endtask
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [7:0] i_cfg_data   = 8'h00;
    logic       i_in_valid   = 1'b0;
    logic       i_key_down   = 1'b0;
    logic       i_clear_all  = 1'b0;
    logic       i_show_text  = 1'b0;
    logic       i_end_letter = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_event_kind;
    logic [7:0] o_letter;
    logic       o_last;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    morse_scoreboard sb = new();

    morse_key_decoder #(
        .MAX_LETTERS(LETTERS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_key_down  (i_key_down),
        .i_clear_all (i_clear_all),
        .i_show_text (i_show_text),
        .i_end_letter(i_end_letter),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_event_kind(o_event_kind),
        .o_letter    (o_letter),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("FAIL morse_key_decoder");
        $finish;
    end

    // Output side: check every transfer, then pick the stall for the next edge.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_event(o_event_kind, o_letter, o_last);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(0, 99) < 11);
            end
        end
    end

    task automatic send_tick(input bit key, input bit clr, input bit show, input bit endl);
        int gap;
        if (!steady && $urandom_range(0, 99) < 11) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_key_down   <= key;
        i_clear_all  <= clr;
        i_show_text  <= show;
        i_end_letter <= endl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.apply_tick(key, clr, show, endl);
    endtask

    // Hold the key for a number of ticks, then release it.
    task automatic press(input int ticks, input bit show, input bit endl);
        repeat (ticks) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, show, endl);
    endtask

    // Stop offering ticks and let the block finish, including a tick that
    // may still be in work without any result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] thr);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.dash_thr = thr;
    endtask

    // Mostly well-formed presses with random length and random show, end and
    // clear requests on release, mixed with some ticks of random flags.
    task automatic random_ticks(input int count, input int max_hold);
        int left;
        int r;
        bit down;
        bit key, clr, show, endl;
        left = 0;
        down = 1'b0;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                key  = 1'($urandom_range(0, 1));
                clr  = 1'($urandom_range(0, 1));
                show = 1'($urandom_range(0, 1));
                endl = 1'($urandom_range(0, 1));
            end else if (left > 0) begin
                key  = 1'b1;
                clr  = 1'b0;
                show = r < 14;
                endl = 1'b0;
                left--;
            end else if (down || r < 25) begin
                key  = 1'b0;
                clr  = $urandom_range(0, 99) < 3;
                show = $urandom_range(0, 99) < 12;
                endl = $urandom_range(0, 99) < 20;
            end else begin
                key  = 1'b1;
                clr  = 1'b0;
                show = 1'b0;
                endl = 1'b0;
                left = $urandom_range(0, max_hold - 1);
            end
            down = key;
            send_tick(key, clr, show, endl);
        end
    endtask

    initial begin
        int thr;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Threshold at its reset value.
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        press(1, 1'b0, 1'b0);
        press(3, 1'b1, 1'b1);
        press(2, 1'b0, 1'b0);
        press(1, 1'b0, 1'b0);
        press(1, 1'b0, 1'b0);
        // The fourth symbol closes the letter; end-letter then closes an empty one.
        press(1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 1'b1);
        repeat (15) send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        // Store is full now: this close and the next release are dropped.
        send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        press(1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);

        // Every press is a dash; the output holds off while ticks keep coming.
        write_threshold(8'd0);
        steady   = 1'b1;
        hold_req = 1'b1;
        random_ticks(30, 3);
        steady   = 1'b0;

        // No press is a dash at the top threshold.
        write_threshold(8'd255);
        press(5, 1'b1, 1'b1);
        random_ticks(10, 4);

        thr = $urandom_range(1, 5);
        write_threshold(thr[7:0]);
        random_ticks(20, thr + 3);

        settle();
        repeat (15) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("PASS morse_key_decoder");
        else
            $display("FAIL morse_key_decoder");
        $finish;
    end

endmodule
